// File: rtl/core/i64alu_pkg.sv
// ============================================================================
// i64alu_pkg
// Shared types and constants for the 64-bit integer ALU: operation codes,
// decoded control word and the items carried by the internal queues.
// ============================================================================
package i64alu_pkg;

    localparam int FIELD_W         = 64;
    localparam int OP_W            = 5;
    localparam int COUNT_W         = 8;
    localparam int DATA_WIDTH_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF   = 2;
    localparam int MUL_CHUNK       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_AND  = 5'd3,
        OP_OR   = 5'd4,
        OP_XOR  = 5'd5,
        OP_SHL  = 5'd6,
        OP_LSHR = 5'd7,
        OP_ASHR = 5'd8,
        OP_NEG  = 5'd9,
        OP_ABS  = 5'd10,
        OP_INC  = 5'd11,
        OP_DEC  = 5'd12,
        OP_EQ   = 5'd13,
        OP_NE   = 5'd14,
        OP_LT   = 5'd15,
        OP_GT   = 5'd16,
        OP_LE   = 5'd17,
        OP_GE   = 5'd18,
        OP_SIGN = 5'd19
    } op_t;

    typedef enum logic [2:0] {
        UNIT_ADD,
        UNIT_MUL,
        UNIT_LOGIC,
        UNIT_SHIFT,
        UNIT_CMP,
        UNIT_SIGN,
        UNIT_ZERO
    } unit_t;

    typedef enum logic [1:0] {
        RHS_B,
        RHS_ONE,
        RHS_A
    } rhs_t;

    typedef enum logic [1:0] {
        NEG_NEVER,
        NEG_ALWAYS,
        NEG_IF_A_NEG
    } neg_t;

    typedef enum logic [1:0] {
        LOP_AND,
        LOP_OR,
        LOP_XOR
    } logic_op_t;

    typedef enum logic [1:0] {
        SHK_SHL,
        SHK_LSHR,
        SHK_ASHR
    } shift_kind_t;

    typedef enum logic [2:0] {
        CMP_EQ,
        CMP_NE,
        CMP_LT,
        CMP_GT,
        CMP_LE,
        CMP_GE
    } cmp_t;

    typedef struct packed {
        unit_t       unit;
        logic        lhs_zero;
        rhs_t        rhs;
        neg_t        neg;
        logic_op_t   lop;
        shift_kind_t shk;
        cmp_t        cmp;
    } ctrl_t;

    typedef struct packed {
        ctrl_t                     ctrl;
        logic signed [FIELD_W-1:0] operand_a;
        logic signed [FIELD_W-1:0] operand_b;
        logic signed [COUNT_W-1:0] shift_count;
    } work_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] result_value;
        logic                      compare_flag;
    } result_t;

endpackage

// File: rtl/core/i64alu_fifo.sv
// ============================================================================
// i64alu_fifo
// Small register FIFO used between the front and back ends and on the
// result side.
// ============================================================================
module i64alu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/i64alu_front.sv
// ============================================================================
// i64alu_front
// Input side: takes items and decodes the operation code into a control
// word for the execution pipeline.
// ============================================================================
module i64alu_front (
    input  logic                                    push,
    output logic                                    full,
    input  logic [i64alu_pkg::OP_W-1:0]             req_type,
    input  logic signed [i64alu_pkg::FIELD_W-1:0]   operand_a,
    input  logic signed [i64alu_pkg::FIELD_W-1:0]   operand_b,
    input  logic signed [i64alu_pkg::COUNT_W-1:0]  shift_count,
    output logic                                    q_push,
    output i64alu_pkg::work_t                       q_item,
    input  logic                                    q_full
);

    i64alu_pkg::ctrl_t ctrl;

    assign full   = q_full;
    assign q_push = push;

    always_comb
    begin
        ctrl.unit     = i64alu_pkg::UNIT_ZERO;
        ctrl.lhs_zero = 1'b0;
        ctrl.rhs      = i64alu_pkg::RHS_B;
        ctrl.neg      = i64alu_pkg::NEG_NEVER;
        ctrl.lop      = i64alu_pkg::LOP_AND;
        ctrl.shk      = i64alu_pkg::SHK_SHL;
        ctrl.cmp      = i64alu_pkg::CMP_EQ;
        case (i64alu_pkg::op_t'(req_type))
            i64alu_pkg::OP_ADD:
            begin
                ctrl.unit = i64alu_pkg::UNIT_ADD;
            end
            i64alu_pkg::OP_SUB:
            begin
                ctrl.unit = i64alu_pkg::UNIT_ADD;
                ctrl.neg  = i64alu_pkg::NEG_ALWAYS;
            end
            i64alu_pkg::OP_MUL:  ctrl.unit = i64alu_pkg::UNIT_MUL;
            i64alu_pkg::OP_AND:
            begin
                ctrl.unit = i64alu_pkg::UNIT_LOGIC;
                ctrl.lop  = i64alu_pkg::LOP_AND;
            end
            i64alu_pkg::OP_OR:
            begin
                ctrl.unit = i64alu_pkg::UNIT_LOGIC;
                ctrl.lop  = i64alu_pkg::LOP_OR;
            end
            i64alu_pkg::OP_XOR:
            begin
                ctrl.unit = i64alu_pkg::UNIT_LOGIC;
                ctrl.lop  = i64alu_pkg::LOP_XOR;
            end
            i64alu_pkg::OP_SHL:
            begin
                ctrl.unit = i64alu_pkg::UNIT_SHIFT;
                ctrl.shk  = i64alu_pkg::SHK_SHL;
            end
            i64alu_pkg::OP_LSHR:
            begin
                ctrl.unit = i64alu_pkg::UNIT_SHIFT;
                ctrl.shk  = i64alu_pkg::SHK_LSHR;
            end
            i64alu_pkg::OP_ASHR:
            begin
                ctrl.unit = i64alu_pkg::UNIT_SHIFT;
                ctrl.shk  = i64alu_pkg::SHK_ASHR;
            end
            i64alu_pkg::OP_NEG:
            begin
                ctrl.unit     = i64alu_pkg::UNIT_ADD;
                ctrl.lhs_zero = 1'b1;
                ctrl.rhs      = i64alu_pkg::RHS_A;
                ctrl.neg      = i64alu_pkg::NEG_ALWAYS;
            end
            i64alu_pkg::OP_ABS:
            begin
                ctrl.unit     = i64alu_pkg::UNIT_ADD;
                ctrl.lhs_zero = 1'b1;
                ctrl.rhs      = i64alu_pkg::RHS_A;
                ctrl.neg      = i64alu_pkg::NEG_IF_A_NEG;
            end
            i64alu_pkg::OP_INC:
            begin
                ctrl.unit = i64alu_pkg::UNIT_ADD;
                ctrl.rhs  = i64alu_pkg::RHS_ONE;
            end
            i64alu_pkg::OP_DEC:
            begin
                ctrl.unit = i64alu_pkg::UNIT_ADD;
                ctrl.rhs  = i64alu_pkg::RHS_ONE;
                ctrl.neg  = i64alu_pkg::NEG_ALWAYS;
            end
            i64alu_pkg::OP_EQ:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_EQ;
            end
            i64alu_pkg::OP_NE:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_NE;
            end
            i64alu_pkg::OP_LT:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_LT;
            end
            i64alu_pkg::OP_GT:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_GT;
            end
            i64alu_pkg::OP_LE:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_LE;
            end
            i64alu_pkg::OP_GE:
            begin
                ctrl.unit = i64alu_pkg::UNIT_CMP;
                ctrl.cmp  = i64alu_pkg::CMP_GE;
            end
            i64alu_pkg::OP_SIGN: ctrl.unit = i64alu_pkg::UNIT_SIGN;
            default:             ctrl.unit = i64alu_pkg::UNIT_ZERO;
        endcase
    end

    always_comb
    begin
        q_item.ctrl        = ctrl;
        q_item.operand_a   = operand_a;
        q_item.operand_b   = operand_b;
        q_item.shift_count = shift_count;
    end

endmodule

// File: rtl/core/i64alu_back.sv
// ============================================================================
// i64alu_back
// Two-stage execution pipeline: stage 1 runs adder, logic, shifter,
// comparator, sign unit and the partial products; stage 2 sums the
// products and picks the result.
// ============================================================================
module i64alu_back #(
    parameter int DATA_WIDTH = i64alu_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  i64alu_pkg::work_t    in_item,
    output logic                 in_pop,
    output logic                 out_push,
    output i64alu_pkg::result_t  out_item,
    input  logic                 out_full
);

    localparam int W      = DATA_WIDTH;
    localparam int CH     = i64alu_pkg::MUL_CHUNK;
    localparam int NCH    = (W + CH - 1) / CH;
    localparam int PROD_W = NCH * CH;
    localparam int CNT_W  = i64alu_pkg::COUNT_W;

    logic                en;

    // stage 1 operands and unit outputs
    logic [W-1:0]        a_w, b_w;
    logic [W-1:0]        lhs, rhs, rhs_x, add_res;
    logic                inv;
    logic [W-1:0]        log_res;
    logic [CNT_W-1:0]    cnt_u, sh_mag;
    logic                sh_neg;
    logic [W-1:0]        sh_left, sh_lright, sh_aright, sh_res;
    logic                eq, lt_ab, lt_ba, cmp_flag;
    logic [W-1:0]        sign_res;
    logic [W-1:0]        s1_res_next;
    logic                s1_flag_next;
    logic [PROD_W-1:0]   a_pad, b_pad;
    logic [2*CH-1:0]     pp_next [NCH][NCH];

    // pipeline registers
    logic                s1_valid_reg;
    logic                s1_mul_reg;
    logic [W-1:0]        s1_res_reg;
    logic                s1_flag_reg;
    logic [2*CH-1:0]     pp_reg [NCH][NCH];
    logic                s2_valid_reg;
    logic [W-1:0]        s2_res_reg;
    logic                s2_flag_reg;
    logic [PROD_W-1:0]   mul_acc;
    logic [W-1:0]        s2_res_next;

    assign en       = !s2_valid_reg || !out_full;
    assign in_pop   = en && in_valid;
    assign out_push = s2_valid_reg && !out_full;

    assign a_w = W'(in_item.operand_a);
    assign b_w = W'(in_item.operand_b);

    // adder shared by add, sub, neg, abs, inc, dec
    always_comb
    begin
        lhs = in_item.ctrl.lhs_zero ? '0 : a_w;
        case (in_item.ctrl.rhs)
            i64alu_pkg::RHS_B:   rhs = b_w;
            i64alu_pkg::RHS_ONE: rhs = W'(1);
            i64alu_pkg::RHS_A:   rhs = a_w;
            default:             rhs = b_w;
        endcase
        case (in_item.ctrl.neg)
            i64alu_pkg::NEG_NEVER:    inv = 1'b0;
            i64alu_pkg::NEG_ALWAYS:   inv = 1'b1;
            i64alu_pkg::NEG_IF_A_NEG: inv = a_w[W-1];
            default:                  inv = 1'b0;
        endcase
        rhs_x   = inv ? ~rhs : rhs;
        add_res = lhs + rhs_x + W'(inv);
    end

    always_comb
    begin
        case (in_item.ctrl.lop)
            i64alu_pkg::LOP_AND: log_res = a_w & b_w;
            i64alu_pkg::LOP_OR:  log_res = a_w | b_w;
            i64alu_pkg::LOP_XOR: log_res = a_w ^ b_w;
            default:             log_res = a_w & b_w;
        endcase
    end

    // shifter; a negative count reverses direction, counts of W or more
    // give zero or sign fill through the shift operators themselves
    always_comb
    begin
        cnt_u     = in_item.shift_count;
        sh_neg    = cnt_u[CNT_W-1];
        sh_mag    = sh_neg ? (CNT_W'(0) - cnt_u) : cnt_u;
        sh_left   = a_w << sh_mag;
        sh_lright = a_w >> sh_mag;
        sh_aright = W'($signed(a_w) >>> sh_mag);
        case (in_item.ctrl.shk)
            i64alu_pkg::SHK_SHL:  sh_res = sh_neg ? sh_lright : sh_left;
            i64alu_pkg::SHK_LSHR: sh_res = sh_neg ? sh_left : sh_lright;
            i64alu_pkg::SHK_ASHR: sh_res = sh_neg ? sh_left : sh_aright;
            default:              sh_res = sh_left;
        endcase
    end

    always_comb
    begin
        eq    = (a_w == b_w);
        lt_ab = ($signed(a_w) < $signed(b_w));
        lt_ba = ($signed(b_w) < $signed(a_w));
        case (in_item.ctrl.cmp)
            i64alu_pkg::CMP_EQ: cmp_flag = eq;
            i64alu_pkg::CMP_NE: cmp_flag = !eq;
            i64alu_pkg::CMP_LT: cmp_flag = lt_ab;
            i64alu_pkg::CMP_GT: cmp_flag = lt_ba;
            i64alu_pkg::CMP_LE: cmp_flag = !lt_ba;
            i64alu_pkg::CMP_GE: cmp_flag = !lt_ab;
            default:            cmp_flag = 1'b0;
        endcase
    end

    always_comb
    begin
        if (a_w == '0)
        begin
            sign_res = '0;
        end
        else if (a_w[W-1])
        begin
            sign_res = '1;
        end
        else
        begin
            sign_res = W'(1);
        end
    end

    always_comb
    begin
        s1_flag_next = 1'b0;
        case (in_item.ctrl.unit)
            i64alu_pkg::UNIT_ADD:   s1_res_next = add_res;
            i64alu_pkg::UNIT_LOGIC: s1_res_next = log_res;
            i64alu_pkg::UNIT_SHIFT: s1_res_next = sh_res;
            i64alu_pkg::UNIT_CMP:
            begin
                s1_res_next  = W'(cmp_flag);
                s1_flag_next = cmp_flag;
            end
            i64alu_pkg::UNIT_SIGN:  s1_res_next = sign_res;
            default:                s1_res_next = '0;
        endcase
    end

    // CH x CH partial products; only those landing in the low W bits
    always_comb
    begin
        a_pad = PROD_W'(a_w);
        b_pad = PROD_W'(b_w);
        for (int i = 0; i < NCH; i++)
        begin
            for (int j = 0; j < NCH; j++)
            begin
                if (i + j < NCH)
                begin
                    pp_next[i][j] = a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
                end
                else
                begin
                    pp_next[i][j] = '0;
                end
            end
        end
    end

    always_comb
    begin
        mul_acc = '0;
        for (int i = 0; i < NCH; i++)
        begin
            for (int j = 0; j < NCH; j++)
            begin
                if (i + j < NCH)
                begin
                    mul_acc = mul_acc + (PROD_W'(pp_reg[i][j]) << ((i + j) * CH));
                end
            end
        end
        s2_res_next = s1_mul_reg ? mul_acc[W-1:0] : s1_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mul_reg  <= (in_item.ctrl.unit == i64alu_pkg::UNIT_MUL);
            s1_res_reg  <= s1_res_next;
            s1_flag_reg <= s1_flag_next;
            pp_reg      <= pp_next;
            s2_res_reg  <= s2_res_next;
            s2_flag_reg <= s1_flag_reg;
        end
    end

    always_comb
    begin
        out_item.result_value = i64alu_pkg::FIELD_W'($signed(s2_res_reg));
        out_item.compare_flag = s2_flag_reg;
    end

endmodule

// File: rtl/core/int64_alu_top.sv
// ============================================================================
// int64_alu_top
// Signed integer ALU: add/sub/mul, bitwise logic, shifts, unary ops,
// comparisons and sign, with queue-style handshakes on both sides.
// ============================================================================
// Throughput is one item per clock while the result queue is not full; an item
// pushed passes through the input queue, the two execute stages and then the
// result queue before it can be popped at the result ports. The depth of the
// execute pipeline is set by the multiplier, which forms 32x32 partial
// products in the first stage and sums them in the second. The front end
// decodes req_type and writes the item into a short queue; full rises only
// when that queue is full. The back end stalls on its own when the result
// queue is full, so a slow consumer back-pressures through the pipeline while
// the front keeps filling its queue. Results come out in push order, one per
// item. Arithmetic wraps at DATA_WIDTH bits and result_value is that value
// sign-extended to 64 bits. Comparisons set compare_flag and return it as
// result_value; every other operation leaves the flag low. Codes 20 to 31
// give zero and a low flag.
// ============================================================================
module int64_alu_top #(
    parameter int DATA_WIDTH  = i64alu_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i64alu_pkg::QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = i64alu_pkg::OUT_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // item input
    input  logic                                   push,
    output logic                                   full,
    input  logic [i64alu_pkg::OP_W-1:0]            req_type,
    input  logic signed [i64alu_pkg::FIELD_W-1:0]  operand_a,
    input  logic signed [i64alu_pkg::FIELD_W-1:0]  operand_b,
    input  logic signed [i64alu_pkg::COUNT_W-1:0]  shift_count,
    // result output
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [i64alu_pkg::FIELD_W-1:0]  result_value,
    output logic                                   compare_flag
);

    localparam int WORK_W = $bits(i64alu_pkg::work_t);
    localparam int RES_W  = $bits(i64alu_pkg::result_t);

    // front -> work queue
    logic                  fq_push;
    logic                  fq_full;
    i64alu_pkg::work_t     fq_item;

    // work queue -> back end
    logic                  wq_empty;
    logic                  wq_pop;
    logic [WORK_W-1:0]     wq_data;
    i64alu_pkg::work_t     wq_item;

    // back end -> result queue
    logic                  rq_push;
    logic                  rq_full;
    i64alu_pkg::result_t   rq_item;
    logic [RES_W-1:0]      rq_data;
    i64alu_pkg::result_t   res_item;

    i64alu_front u_front (
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .shift_count (shift_count),
        .q_push      (fq_push),
        .q_item      (fq_item),
        .q_full      (fq_full)
    );

    // decouples decode from execution
    i64alu_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_push),
        .wr_data (fq_item),
        .full    (fq_full),
        .rd_en   (wq_pop),
        .rd_data (wq_data),
        .empty   (wq_empty)
    );

    assign wq_item = wq_data;

    i64alu_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!wq_empty),
        .in_item  (wq_item),
        .in_pop   (wq_pop),
        .out_push (rq_push),
        .out_item (rq_item),
        .out_full (rq_full)
    );

    // result queue: the head item is shown on the result ports
    i64alu_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (rq_item),
        .full    (rq_full),
        .rd_en   (pop),
        .rd_data (rq_data),
        .empty   (empty)
    );

    assign res_item     = rq_data;
    assign result_value = res_item.result_value;
    assign compare_flag = res_item.compare_flag;

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// int64_alu_top testbench
// Pushes a short table of corner-case items and then about 2000 random ones
// through the queue handshake and checks every result, field by field and in
// push order, against the table's written values or a behavioural ALU model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import i64alu_pkg::*;

    localparam int DATA_W      = 64;
    localparam int PHASE_ITEMS = 500;
    localparam int DRAIN_WAIT  = 10;

    // codes past OP_SIGN have no operation behind them
    localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 5'd20;
    localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 5'd31;

    localparam logic signed [DATA_W-1:0] S_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [DATA_W-1:0] S_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [DATA_W-1:0] S_ONES = -64'sd1;

    // one row of the directed table; want_* only count when has_want is set
    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [DATA_W-1:0]  a;
        logic signed [DATA_W-1:0]  b;
        logic signed [COUNT_W-1:0] cnt;
        bit                        has_want;
        logic signed [DATA_W-1:0]  want_value;
        logic                      want_flag;
    } alu_vector_t;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      push         = 1'b0;
    logic                      pop          = 1'b0;
    logic [OP_W-1:0]           req_type     = '0;
    logic signed [DATA_W-1:0]  operand_a    = '0;
    logic signed [DATA_W-1:0]  operand_b    = '0;
    logic signed [COUNT_W-1:0] shift_count  = '0;
    logic                      full;
    logic                      empty;
    logic signed [DATA_W-1:0]  result_value;
    logic                      compare_flag;

    // Results still owed by the ALU, oldest first
    result_t     owed_results[$];
    alu_vector_t corner_table[$];
    int          mismatch_count = 0;
    // Idle/stall odds in percent, changed per phase by the stimulus process
    int          push_idle_pct  = 0;
    int          pop_stall_pct  = 0;

    int64_alu_top #(
        .DATA_WIDTH (DATA_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .shift_count  (shift_count),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .compare_flag (compare_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Async reset, held low from time zero and released on a clock edge
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL int64_alu_top");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Behavioural ALU: the result and flag that one item should give.
    // Shift counts are signed; a negative count turns the shift round, and a
    // distance of 64 or more clears the value (sign fill for ashr right).
    // ------------------------------------------------------------------------
    function automatic result_t alu_predict(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b,
                                            input logic signed [COUNT_W-1:0] cnt);
        result_t    res;
        logic [8:0] shamt;
        logic       is_cmp;
        shamt  = cnt[COUNT_W-1] ? 9'd256 - {1'b0, cnt} : {1'b0, cnt};
        is_cmp = 1'b0;
        res    = '0;
        case (op)
            OP_ADD:  res.result_value = a + b;
            OP_SUB:  res.result_value = a - b;
            OP_MUL:  res.result_value = a * b;
            OP_AND:  res.result_value = a & b;
            OP_OR:   res.result_value = a | b;
            OP_XOR:  res.result_value = a ^ b;
            OP_SHL, OP_LSHR, OP_ASHR:
            begin
                if (shamt >= DATA_W)
                    res.result_value = (op == OP_ASHR && !cnt[COUNT_W-1] && a[DATA_W-1])
                                       ? S_ONES : '0;
                else if ((op == OP_SHL) != cnt[COUNT_W-1])
                    res.result_value = a << shamt;
                else if (op == OP_ASHR)
                    res.result_value = a >>> shamt;
                else
                    res.result_value = a >> shamt;
            end
            OP_NEG:  res.result_value = -a;
            OP_ABS:  res.result_value = a[DATA_W-1] ? -a : a;
            OP_INC:  res.result_value = a + 1;
            OP_DEC:  res.result_value = a - 1;
            OP_EQ:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a == b);
            end
            OP_NE:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a != b);
            end
            OP_LT:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a < b);
            end
            OP_GT:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a > b);
            end
            OP_LE:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a <= b);
            end
            OP_GE:
            begin
                is_cmp = 1'b1;
                res.compare_flag = (a >= b);
            end
            OP_SIGN: res.result_value = (a == 0) ? '0 : (a[DATA_W-1] ? S_ONES : 64'sd1);
            default: res = '0;
        endcase
        // comparisons hand the flag back as the value as well
        if (is_cmp)
            res.result_value = {{(DATA_W-1){1'b0}}, res.compare_flag};
        return res;
    endfunction

    // Operand mix: corners, small numbers around zero, and full-width noise
    function automatic logic signed [DATA_W-1:0] random_operand();
        logic signed [DATA_W-1:0] corner[7];
        corner = '{'0, 64'sd1, S_ONES, S_MIN, S_MAX, S_MIN + 1, S_MAX - 1};
        case ($urandom_range(7))
            0:       return corner[$urandom_range(6)];
            1:       return 64'($urandom_range(200)) - 64'sd100;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic signed [COUNT_W-1:0] random_count();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(70));
            1:       return -8'($urandom_range(70));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_vector(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] a,
                              input logic signed [DATA_W-1:0] b,
                              input logic signed [COUNT_W-1:0] cnt,
                              input bit has_want,
                              input logic signed [DATA_W-1:0] want_value,
                              input logic want_flag);
        alu_vector_t row;
        row = '{op, a, b, cnt, has_want, want_value, want_flag};
        corner_table.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Push one item. Called right after the clock rises. Idles at random first,
    // then holds push high until an edge sees full low. push is never lowered
    // between back-to-back items, so each step carries one update of it.
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [OP_W-1:0] op,
                             input logic signed [DATA_W-1:0] a,
                             input logic signed [DATA_W-1:0] b,
                             input logic signed [COUNT_W-1:0] cnt,
                             input bit has_want,
                             input result_t want);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        req_type    <= op;
        operand_a   <= a;
        operand_b   <= b;
        shift_count <= cnt;
        do
            @(posedge clk);
        while (full);
        // accepted at this edge: book what it owes us
        owed_results.push_back(has_want ? want : alu_predict(op, a, b, cnt));
    endtask

    // Stall the pop side at the phase's odds; one decision per edge
    always @(posedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    // ------------------------------------------------------------------------
    // Checker: outputs are read at the edge, before the flops move, so a pop
    // seen here is the item accepted at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got value %h flag %b",
                         $time, result_value, compare_flag);
            end
            else
            begin
                want = owed_results.pop_front();
                if (result_value !== want.result_value)
                begin
                    mismatch_count++;
                    $display("%0t: result_value mismatch: expected %h, got %h",
                             $time, want.result_value, result_value);
                end
                if (compare_flag !== want.compare_flag)
                begin
                    mismatch_count++;
                    $display("%0t: compare_flag mismatch: expected %b, got %b",
                             $time, want.compare_flag, compare_flag);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        alu_vector_t              row;
        result_t                  want;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        int                       idle_by_phase[4];
        int                       stall_by_phase[4];

        // phases: free running, slow sender, slow receiver, both a bit slow
        idle_by_phase  = '{0, 77, 0, 25};
        stall_by_phase = '{0, 0, 77, 25};

        // Directed corners. Expected values are written out where obvious;
        // rows with has_want clear go through the model.
        add_vector(OP_ADD,  S_MAX,  64'sd1, 8'sd0,    1, S_MIN, 1'b0);  // wraps
        add_vector(OP_SUB,  S_MIN,  64'sd1, 8'sd0,    1, S_MAX, 1'b0);  // wraps
        add_vector(OP_MUL,  S_MIN,  S_ONES, 8'sd0,    1, S_MIN, 1'b0);
        add_vector(OP_AND,  S_ONES, 64'sh0123_4567_89ab_cdef, 8'sd0, 0, '0, 1'b0);
        add_vector(OP_OR,   S_MIN,  64'sh0f0f_0f0f_f0f0_f0f0, 8'sd0, 0, '0, 1'b0);
        add_vector(OP_XOR,  S_ONES, S_ONES, 8'sd0,    1, '0, 1'b0);
        add_vector(OP_SHL,  64'sd1, '0,     8'sd63,   1, S_MIN, 1'b0);
        // negative count on shl: logical right, no sign fill
        add_vector(OP_SHL,  S_MIN,  '0,     -8'sd1,   1, 64'sh4000_0000_0000_0000, 1'b0);
        add_vector(OP_SHL,  S_ONES, '0,     8'sd64,   1, '0, 1'b0);
        add_vector(OP_LSHR, S_ONES, '0,     8'sd127,  1, '0, 1'b0);
        add_vector(OP_LSHR, 64'sd1, '0,     -8'sd128, 1, '0, 1'b0);
        add_vector(OP_LSHR, 64'sh00de_adbe_ef00_1234, '0, -8'sd4, 0, '0, 1'b0);
        add_vector(OP_ASHR, S_MIN,  '0,     8'sd100,  1, S_ONES, 1'b0); // sign fill
        add_vector(OP_ASHR, S_MIN,  '0,     8'sd0,    1, S_MIN, 1'b0);  // pass through
        add_vector(OP_NEG,  S_MIN,  '0,     8'sd0,    1, S_MIN, 1'b0);
        add_vector(OP_ABS,  S_MIN,  '0,     8'sd0,    1, S_MIN, 1'b0);  // wraps to itself
        add_vector(OP_INC,  S_MAX,  '0,     8'sd0,    1, S_MIN, 1'b0);
        add_vector(OP_DEC,  S_MIN,  '0,     8'sd0,    1, S_MAX, 1'b0);
        add_vector(OP_EQ,   64'sd5, 64'sd5, 8'sd0,    1, 64'sd1, 1'b1);
        add_vector(OP_NE,   64'sd5, 64'sd5, 8'sd0,    1, '0, 1'b0);
        add_vector(OP_LT,   S_MIN,  S_MAX,  8'sd0,    1, 64'sd1, 1'b1); // signed compare
        add_vector(OP_GT,   S_MIN,  S_MAX,  8'sd0,    1, '0, 1'b0);
        add_vector(OP_LE,   64'sd7, 64'sd7, 8'sd0,    1, 64'sd1, 1'b1);
        add_vector(OP_GE,   S_MAX,  S_MIN,  8'sd0,    1, 64'sd1, 1'b1);
        add_vector(OP_SIGN, S_MIN,  '0,     8'sd0,    1, S_ONES, 1'b0); // flag stays low
        add_vector(OP_UNDEF_LAST, S_ONES, S_ONES, -8'sd1, 1, '0, 1'b0);

        wait (rst_n);
        @(posedge clk);

        foreach (corner_table[i])
        begin
            row  = corner_table[i];
            want = '{row.want_value, row.want_flag};
            push_item(row.op, row.a, row.b, row.cnt, row.has_want, want);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            // hold off until the pipe has drained, then change the odds
            push <= 1'b0;
            while (owed_results.size() != 0)
                @(posedge clk);
            push_idle_pct = idle_by_phase[phase];
            pop_stall_pct = stall_by_phase[phase];

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 8)
                    op = 5'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
                else
                    op = 5'($urandom_range(OP_SIGN));
                a = random_operand();
                b = random_operand();
                // comparisons need equal and neighbouring operands to be useful
                if (op >= OP_EQ && op <= OP_GE)
                begin
                    case ($urandom_range(3))
                        0:       b = a;
                        1:       b = a + 1;
                        2:       b = a - 1;
                        default: ;
                    endcase
                end
                push_item(op, a, b, random_count(), 0, '0);
            end
        end

        push <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        // keep clocking a while longer to catch anything extra coming out
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS int64_alu_top");
        else
            $display("FAIL int64_alu_top");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/i64alu_pkg.sv
rtl/core/i64alu_fifo.sv
rtl/core/i64alu_front.sv
rtl/core/i64alu_back.sv
rtl/core/int64_alu_top.sv
sim/testbench.sv
